// ===== rtl/core/olsd_pkg.sv =====
// Shared types, constants and helpers for the ordered list search/delete block.
// No dependencies.
package olsd_pkg;

  localparam int CAPACITY = 16;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int POS_W    = 4;

  localparam logic [1:0] MODE_APPEND  = 2'd0;
  localparam logic [1:0] MODE_PREPEND = 2'd1;
  localparam logic [1:0] MODE_SEARCH  = 2'd2;
  localparam logic [1:0] MODE_DELETE  = 2'd3;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [1:0] STAT_FULL      = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_SCAN,
    ST_SHIFT,
    ST_RESULT
  } state_t;

  // Next slot around the ring.
  function automatic logic [ADDR_W-1:0] slot_inc(input logic [ADDR_W-1:0] s);
    if (s == ADDR_W'(CAPACITY - 1)) begin
      return '0;
    end
    return s + ADDR_W'(1);
  endfunction

  // Previous slot around the ring.
  function automatic logic [ADDR_W-1:0] slot_dec(input logic [ADDR_W-1:0] s);
    if (s == '0) begin
      return ADDR_W'(CAPACITY - 1);
    end
    return s - ADDR_W'(1);
  endfunction

  // Slot of the entry just past the tail; both operands stay below CAPACITY.
  function automatic logic [ADDR_W-1:0] slot_add(input logic [ADDR_W-1:0] s,
                                                 input logic [CNT_W-1:0]  n);
    logic [CNT_W:0] sum;
    sum = {1'b0, CNT_W'(s)} + {1'b0, n};
    if (sum >= (CNT_W + 1)'(CAPACITY)) begin
      sum = sum - (CNT_W + 1)'(CAPACITY);
    end
    return sum[ADDR_W-1:0];
  endfunction

endpackage

// ===== rtl/core/olsd_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module olsd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/ordered_list_search_delete.sv =====
// Ordered list of signed values kept as a ring in one RAM; append, prepend,
// search and delete-first-match, one result beat per command beat.
// Depends on olsd_pkg and olsd_ram.
//
//   channel | beat contents                 | handshake
//   in      | mode, value                   | in_valid / in_stall
//   out     | status, position, list_empty  | out_valid / out_stall
//
// Append and prepend pass from accept through ST_START and ST_RESULT to the result register.
// Search walks the list one entry per cycle through the RAM read port,
// from the head until it finds a match or reaches the last entry.
// Delete walks to the match, then moves each later entry one slot toward
// the head, one read and one write per cycle.
// Reset empties the list; no RAM clearing is needed.
// A new command is taken while a finished result still waits on out_stall.
module ordered_list_search_delete (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          mode,
  input  logic signed [31:0]  value,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          status,
  output logic [3:0]          position,
  output logic                list_empty
);
  import olsd_pkg::*;

  state_t              state, state_next;
  logic [1:0]          cmd_mode;
  logic [DATA_W-1:0]   cmd_value;
  logic [CNT_W-1:0]    count, count_next;
  logic [ADDR_W-1:0]   first, first_next;
  logic [CNT_W-1:0]    pos, pos_next;
  logic [ADDR_W-1:0]   slot, slot_next;
  logic [1:0]          res_status, res_status_next;
  logic [POS_W-1:0]    res_pos, res_pos_next;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [DATA_W-1:0]   ram_wdata;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [DATA_W-1:0]   ram_rdata;

  logic                in_fire;
  logic                out_free;
  logic                is_full;
  logic                is_match;
  logic                is_last;

  assign in_fire  = in_valid && !in_stall;
  assign in_stall = (state != ST_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign is_full  = (count == CNT_W'(CAPACITY));
  assign is_match = (ram_rdata == cmd_value);
  assign is_last  = ((pos + CNT_W'(1)) >= count);

  olsd_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          state_next = ST_START;
        end
      end
      ST_START: begin
        if ((cmd_mode == MODE_SEARCH || cmd_mode == MODE_DELETE) && count != '0) begin
          state_next = ST_SCAN;
        end else begin
          state_next = ST_RESULT;
        end
      end
      ST_SCAN: begin
        if (is_match && cmd_mode == MODE_DELETE) begin
          state_next = ST_SHIFT;
        end else if (is_match || is_last) begin
          state_next = ST_RESULT;
        end
      end
      ST_SHIFT: begin
        if (is_last) begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    count_next      = count;
    first_next      = first;
    pos_next        = pos;
    slot_next       = slot;
    res_status_next = res_status;
    res_pos_next    = res_pos;
    ram_we          = 1'b0;
    ram_waddr       = slot;
    ram_wdata       = ram_rdata;
    ram_raddr       = slot_inc(slot);
    case (state)
      ST_START: begin
        res_status_next = STAT_OK;
        res_pos_next    = '0;
        pos_next        = '0;
        slot_next       = first;
        ram_raddr       = first;
        case (cmd_mode)
          MODE_APPEND: begin
            if (is_full) begin
              res_status_next = STAT_FULL;
            end else begin
              ram_we     = 1'b1;
              ram_waddr  = slot_add(first, count);
              ram_wdata  = cmd_value;
              count_next = count + CNT_W'(1);
            end
          end
          MODE_PREPEND: begin
            if (is_full) begin
              res_status_next = STAT_FULL;
            end else begin
              ram_we     = 1'b1;
              ram_waddr  = slot_dec(first);
              ram_wdata  = cmd_value;
              first_next = slot_dec(first);
              count_next = count + CNT_W'(1);
            end
          end
          default: begin
            if (count == '0) begin
              res_status_next = STAT_NOT_FOUND;
            end
          end
        endcase
      end
      ST_SCAN: begin
        // read data belongs to slot; the next slot is fetched speculatively
        if (is_match) begin
          if (cmd_mode == MODE_SEARCH) begin
            res_pos_next = POS_W'(pos);
          end
        end else if (is_last) begin
          res_status_next = STAT_NOT_FOUND;
        end else begin
          pos_next  = pos + CNT_W'(1);
          slot_next = slot_inc(slot);
        end
      end
      ST_SHIFT: begin
        // read data is the entry after slot; pull it one place toward the head
        if (is_last) begin
          count_next = count - CNT_W'(1);
          if (count == CNT_W'(1)) begin
            first_next = '0;
          end
        end else begin
          ram_we    = 1'b1;
          ram_waddr = slot;
          ram_wdata = ram_rdata;
          ram_raddr = slot_inc(slot_inc(slot));
          pos_next  = pos + CNT_W'(1);
          slot_next = slot_inc(slot);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      first     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      first <= first_next;
      if (state == ST_RESULT && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_mode  <= mode;
      cmd_value <= $unsigned(value);
    end
    pos        <= pos_next;
    slot       <= slot_next;
    res_status <= res_status_next;
    res_pos    <= res_pos_next;
    if (state == ST_RESULT && out_free) begin
      status     <= res_status;
      position   <= res_pos;
      list_empty <= (count == '0);
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_first_bound: assert property (@(posedge clk) disable iff (rst)
    first <= ADDR_W'(CAPACITY - 1))
    else $error("head slot out of range");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RESULT && res_status == STAT_FULL) |-> is_full)
    else $error("full reported on a list with room");

  a_accept_start: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> state == ST_START)
    else $error("accepted command did not start");

  a_result_load: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RESULT && out_free) |=> (out_valid && state == ST_IDLE))
    else $error("result not loaded into output register");
`endif

endmodule
